// ----- design/dqnm_pkg.sv -----
// ----------------------------------------------------------------------------
// dqnm_pkg
// Shared types and constants for the DNS query name matcher.
// ----------------------------------------------------------------------------
package dqnm_pkg;

  localparam int PATTERN_DEPTH = 128;
  localparam int PATTERN_AW    = $clog2(PATTERN_DEPTH);

  localparam int          HDR_BYTES       = 12;
  localparam logic [15:0] QUESTION_COUNT  = 16'h0001;
  localparam logic [15:0] FLAGS_RESET     = 16'h0100;
  localparam logic [15:0] QTYPE_RESET     = 16'h0001;
  localparam logic [15:0] COUNT_MAX       = 16'hFFFF;

  localparam int CFG_AW = 4;

  typedef enum logic [1:0] {
    REG_PATTERN_LENGTH = 2'd0,
    REG_EXPECTED_FLAGS = 2'd1,
    REG_WANTED_QTYPE   = 2'd2
  } reg_idx_e;

  typedef enum logic [2:0] {
    VERDICT_MATCH        = 3'd0,
    VERDICT_SHORT_HEADER = 3'd1,
    VERDICT_HEADER_BAD   = 3'd2,
    VERDICT_NAME_BAD     = 3'd3,
    VERDICT_TYPE_BAD     = 3'd4
  } verdict_e;

  typedef struct packed {
    logic [6:0]  pattern_length;
    logic [15:0] expected_flags;
    logic [15:0] wanted_qtype;
  } cfg_t;

endpackage

// ----- design/dqnm_ram.sv -----
// ----------------------------------------------------------------------------
// dqnm_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module dqnm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 128
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- design/dqnm_regs.sv -----
// ----------------------------------------------------------------------------
// dqnm_regs
// APB configuration registers: pattern length, expected flags, wanted qtype.
// ----------------------------------------------------------------------------
module dqnm_regs
  import dqnm_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  output cfg_t              cfg_o
);

  cfg_t     cfg_q;
  logic     wr_en;
  reg_idx_e idx;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;
  assign idx    = reg_idx_e'(paddr[3:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.pattern_length <= '0;
      cfg_q.expected_flags <= FLAGS_RESET;
      cfg_q.wanted_qtype   <= QTYPE_RESET;
    end else if (wr_en) begin
      unique case (idx)
        REG_PATTERN_LENGTH: cfg_q.pattern_length <= pwdata[6:0];
        REG_EXPECTED_FLAGS: cfg_q.expected_flags <= pwdata[15:0];
        REG_WANTED_QTYPE:   cfg_q.wanted_qtype   <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_PATTERN_LENGTH: prdata = {25'd0, cfg_q.pattern_length};
      REG_EXPECTED_FLAGS: prdata = {16'd0, cfg_q.expected_flags};
      REG_WANTED_QTYPE:   prdata = {16'd0, cfg_q.wanted_qtype};
      default:            prdata = '0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

// ----- design/dns_query_name_matcher.sv -----
// ----------------------------------------------------------------------------
// dns_query_name_matcher
// Checks a DNS query payload, one byte per request, against a stored name.
// ----------------------------------------------------------------------------
// Takes one request per cycle while not stalled. A request with func 0 writes
// one byte of the encoded name pattern. A request with func 1 delivers one
// payload byte. The payload byte marked last gives one result (match flag and
// verdict). That result passes from the compare stage into the output
// register, where it is held until out_ready_i takes it. The pattern
// memory is read once per payload byte at acceptance. Its registered data
// meets the byte in the compare stage. The result sits in an output register,
// so input flow continues while a result waits. The input stalls only while
// a final byte in the compare stage faces an earlier result that has not
// been taken yet. A pattern write may be followed at once by a payload byte
// that reads it.
module dns_query_name_matcher
  import dqnm_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic              func_i,
  input  logic [6:0]        pattern_index_i,
  input  logic [7:0]        data_byte_i,
  input  logic              last_byte_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic              is_match_o,
  output logic [2:0]        verdict_o
);

  cfg_t cfg;

  dqnm_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // Intake: byte position and pattern read address
  logic                  in_acc;
  logic                  pay_acc;
  logic [15:0]           pos_q;
  logic [15:0]           pos_d;
  logic [15:0]           name_off;
  logic                  name_off_ok;
  logic                  wr_ok;
  logic [7:0]            pat_rdata;

  assign in_acc      = in_valid_i & in_ready_o;
  assign pay_acc     = in_acc & func_i;
  assign name_off    = pos_q - 16'(HDR_BYTES);
  assign name_off_ok = 32'(name_off) < PATTERN_DEPTH;
  assign wr_ok       = 32'(pattern_index_i) < PATTERN_DEPTH;

  always_comb begin
    pos_d = pos_q;
    if (pay_acc) begin
      if (last_byte_i) begin
        pos_d = '0;
      end else if (pos_q != COUNT_MAX) begin
        pos_d = pos_q + 16'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
    end else begin
      pos_q <= pos_d;
    end
  end

  dqnm_ram #(
    .WIDTH (8),
    .DEPTH (PATTERN_DEPTH)
  ) u_pattern_ram (
    .clk_i   (clk_i),
    .we_i    (in_acc & ~func_i & wr_ok),
    .waddr_i (PATTERN_AW'(pattern_index_i)),
    .wdata_i (data_byte_i),
    .re_i    (pay_acc),
    .raddr_i (name_off[PATTERN_AW-1:0]),
    .rdata_o (pat_rdata)
  );

  // Compare stage
  logic        s1_valid_q;
  logic        s1_last_q;
  logic [15:0] s1_pos_q;
  logic [7:0]  s1_byte_q;
  logic        s1_off_ok_q;
  logic        s1_adv;
  logic        s1_result;
  logic        out_valid_q;
  logic        out_match_q;
  verdict_e    out_verdict_q;

  logic        header_good_q;
  logic        name_good_q;
  logic [7:0]  type_high_q;
  logic [15:0] type_seen_q;
  logic        header_good_d;
  logic        name_good_d;
  logic [7:0]  type_high_d;
  logic [15:0] type_seen_d;

  logic [15:0] name_end;
  logic [15:0] len;
  logic [7:0]  hdr_expect;
  verdict_e    verdict;

  assign s1_result  = s1_valid_q & s1_last_q;
  assign s1_adv     = s1_valid_q & (~s1_last_q | ~out_valid_q | out_ready_i);
  assign in_ready_o = ~s1_valid_q | s1_adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      s1_valid_q <= pay_acc;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pay_acc) begin
      s1_last_q   <= last_byte_i;
      s1_pos_q    <= pos_q;
      s1_byte_q   <= data_byte_i;
      s1_off_ok_q <= name_off_ok;
    end
  end

  assign name_end = 16'(HDR_BYTES) + 16'(cfg.pattern_length);
  assign len      = (s1_pos_q == COUNT_MAX) ? COUNT_MAX : s1_pos_q + 16'd1;

  always_comb begin
    case (s1_pos_q)
      16'd2:   hdr_expect = cfg.expected_flags[15:8];
      16'd3:   hdr_expect = cfg.expected_flags[7:0];
      16'd4:   hdr_expect = QUESTION_COUNT[15:8];
      16'd5:   hdr_expect = QUESTION_COUNT[7:0];
      default: hdr_expect = 8'd0;
    endcase
  end

  always_comb begin
    header_good_d = header_good_q;
    name_good_d   = name_good_q;
    type_high_d   = type_high_q;
    type_seen_d   = type_seen_q;
    if (s1_pos_q >= 16'd2 && s1_pos_q < 16'(HDR_BYTES)) begin
      if (s1_byte_q != hdr_expect) begin
        header_good_d = 1'b0;
      end
    end else if (s1_pos_q >= 16'(HDR_BYTES) && s1_pos_q < name_end) begin
      if (!s1_off_ok_q || pat_rdata != s1_byte_q) begin
        name_good_d = 1'b0;
      end
    end else if (s1_pos_q == name_end + 16'd1) begin
      type_high_d = s1_byte_q;
    end else if (s1_pos_q == name_end + 16'd2) begin
      type_seen_d = {type_high_q, s1_byte_q};
    end
  end

  always_comb begin
    if (len <= 16'(HDR_BYTES)) begin
      verdict = VERDICT_SHORT_HEADER;
    end else if (!header_good_d) begin
      verdict = VERDICT_HEADER_BAD;
    end else if (len < name_end + 16'd4) begin
      verdict = VERDICT_NAME_BAD;
    end else if (!name_good_d) begin
      verdict = VERDICT_NAME_BAD;
    end else if (type_seen_d != cfg.wanted_qtype) begin
      verdict = VERDICT_TYPE_BAD;
    end else begin
      verdict = VERDICT_MATCH;
    end
  end

  // Packet state: clear after the last byte
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      header_good_q <= 1'b1;
      name_good_q   <= 1'b1;
      type_high_q   <= '0;
      type_seen_q   <= '0;
    end else if (s1_adv) begin
      if (s1_last_q) begin
        header_good_q <= 1'b1;
        name_good_q   <= 1'b1;
        type_high_q   <= '0;
        type_seen_q   <= '0;
      end else begin
        header_good_q <= header_good_d;
        name_good_q   <= name_good_d;
        type_high_q   <= type_high_d;
        type_seen_q   <= type_seen_d;
      end
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_adv && s1_result) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv && s1_result) begin
      out_match_q   <= (verdict == VERDICT_MATCH);
      out_verdict_q <= verdict;
    end
  end

  assign out_valid_o = out_valid_q;
  assign is_match_o  = out_match_q;
  assign verdict_o   = out_verdict_q;

endmodule
